@@ src/ubl_pkg.sv @@
// ---------------------------------------------------------------------------
// ubl_pkg : shared types and constants of the uniform block locator
// Item tags between front and back, result record, status codes.
// ---------------------------------------------------------------------------
package ubl_pkg;

  // default row memory depth (columns per row that can be tracked)
  localparam int MAX_WIDTH_DEF = 1024;

  // configuration port
  localparam int   PADDR_W      = 3;
  localparam int   PDATA_W      = 32;
  localparam int   DIM_W        = 10;
  localparam int   REG_SEL_BIT  = 2;
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 10'd10;

  // square size and run entry layout
  localparam int             POS_W   = 11;
  localparam int             RUN_W   = 3;
  localparam int             ENTRY_W = RUN_W + 1;
  localparam logic [RUN_W-1:0] RUN_LEN = 3'd5;

  // decoupling queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef logic signed [POS_W-1:0] pos_t;
  localparam pos_t POS_NONE = '1;   // -1

  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_OTHER = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP_ZERO = 2'd1,
    ST_DUP_ONE  = 2'd2,
    ST_ADJACENT = 2'd3
  } status_t;

  // classified item handed from front to back
  typedef struct packed {
    cls_t cls;
    logic row_first;
    logic col_first;
    logic frame_end;
    pos_t pos_col;
    pos_t pos_row;
  } tag_t;

  typedef struct packed {
    status_t status;
    pos_t    zero_column;
    pos_t    zero_row;
    pos_t    one_column;
    pos_t    one_row;
  } result_t;

endpackage

@@ src/uniform_block_locator.sv @@
// Result path: tag queue, read stage, output buffer. Throughput: one pixel per
//   cycle while in_stall is low; the column run memory does one read and one
//   write per cycle, with a bypass for the same column on successive pixels.
// Reset: synchronous, active low. Afterwards a clearing pass over all MAX_WIDTH
//   entries zeroes the run memory; in_stall stays high for it, configuration
//   writes are taken throughout. Registers reset to a 10 x 10 frame.
// ---------------------------------------------------------------------------
// uniform_block_locator : finds a solid 5x5 square of 0 and one of 1
// Raster pixel stream in, one result item per frame with centres and status.
// ---------------------------------------------------------------------------
module uniform_block_locator #(
  parameter int MAX_WIDTH = ubl_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ubl_pkg::PADDR_W-1:0] paddr,
  input  logic [ubl_pkg::PDATA_W-1:0] pwdata,
  output logic [ubl_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // pixel items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_pixel_value,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic signed [10:0]          out_zero_column,
  output logic signed [10:0]          out_zero_row,
  output logic signed [10:0]          out_one_column,
  output logic signed [10:0]          out_one_row
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  logic [ubl_pkg::DIM_W-1:0] frame_width_r;
  logic [ubl_pkg::DIM_W-1:0] frame_height_r;
  logic                      cfg_wr;

  logic                      push, pop, q_full, q_valid, clearing;
  ubl_pkg::tag_t             push_tag, head_tag;
  logic [ADDR_W-1:0]         push_addr, head_addr;
  ubl_pkg::result_t          result;

  // Registers: word 0 frame width, word 1 frame height. Low address bits are
  // not decoded; always ready, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[ubl_pkg::REG_SEL_BIT] == ubl_pkg::REG_IDX_HEIGHT) ?
                  ubl_pkg::PDATA_W'(frame_height_r) : ubl_pkg::PDATA_W'(frame_width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ubl_pkg::FRAME_DIM_RESET;
      frame_height_r <= ubl_pkg::FRAME_DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[ubl_pkg::REG_SEL_BIT])
        ubl_pkg::REG_IDX_WIDTH:  frame_width_r  <= pwdata[ubl_pkg::DIM_W-1:0];
        ubl_pkg::REG_IDX_HEIGHT: frame_height_r <= pwdata[ubl_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: counts raster position against the frame size, classifies each
  // pixel as 0, 1 or other, and works out where a square ending here sits.
  ubl_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_width    (frame_width_r),
    .frame_height   (frame_height_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .q_full         (q_full),
    .hold           (clearing),
    .push           (push),
    .push_tag       (push_tag),
    .push_addr      (push_addr)
  );

  // Queue: lets the front keep taking pixels while the back waits on the
  // result side.
  ubl_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tag  (push_tag),
    .push_addr (push_addr),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .head_tag  (head_tag),
    .head_addr (head_addr)
  );

  // Back: per-column vertical runs in memory, horizontal run of columns that
  // reached five, duplicate detection, and the per-frame report.
  ubl_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head_tag   (head_tag),
    .head_addr  (head_addr),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (result)
  );

  assign out_status      = result.status;
  assign out_zero_column = result.zero_column;
  assign out_zero_row    = result.zero_row;
  assign out_one_column  = result.one_column;
  assign out_one_row     = result.one_row;

endmodule

@@ src/ubl_front.sv @@
// ---------------------------------------------------------------------------
// ubl_front : pixel intake and classification
// Tracks raster position, classifies the pixel and pushes a tag into the queue.
// ---------------------------------------------------------------------------
module ubl_front #(
  parameter int MAX_WIDTH = ubl_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ubl_pkg::DIM_W-1:0] frame_width,
  input  logic [ubl_pkg::DIM_W-1:0] frame_height,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_pixel_value,
  input  logic                      q_full,
  input  logic                      hold,
  output logic                      push,
  output ubl_pkg::tag_t             push_tag,
  output logic [ADDR_W-1:0]         push_addr
);

  localparam int WW = ((ADDR_W > ubl_pkg::DIM_W) ? ADDR_W : ubl_pkg::DIM_W) + 1;

  logic [ADDR_W-1:0]         col_cnt_r;
  logic [ubl_pkg::DIM_W-1:0] row_cnt_r;
  logic [WW-1:0]             w_eff;
  logic [ubl_pkg::DIM_W-1:0] h_eff;
  logic                      last_col;
  logic                      last_row;

  always_comb begin
    w_eff = (frame_width == '0) ? WW'(1) : WW'(frame_width);
    if (w_eff > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    h_eff    = (frame_height == '0) ? ubl_pkg::DIM_W'(1) : frame_height;
    last_col = (WW'(col_cnt_r) + WW'(1)) >= w_eff;
    last_row = (WW'(row_cnt_r) + WW'(1)) >= WW'(h_eff);
  end

  assign in_stall = q_full | hold;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    unique case (in_pixel_value)
      8'd0:    push_tag.cls = ubl_pkg::CLS_ZERO;
      8'd1:    push_tag.cls = ubl_pkg::CLS_ONE;
      default: push_tag.cls = ubl_pkg::CLS_OTHER;
    endcase
    push_tag.row_first = (row_cnt_r == '0);
    push_tag.col_first = (col_cnt_r == '0);
    push_tag.frame_end = last_col & last_row;
    // centre of a square whose bottom-right pixel is this one
    push_tag.pos_col   = ubl_pkg::POS_W'(col_cnt_r) - ubl_pkg::POS_W'(2);
    push_tag.pos_row   = ubl_pkg::POS_W'(h_eff) - ubl_pkg::POS_W'(row_cnt_r)
                         + ubl_pkg::POS_W'(1);
  end

  assign push_addr = col_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (push) begin
      if (!last_col) begin
        col_cnt_r <= col_cnt_r + ADDR_W'(1);
      end else begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row_cnt_r + ubl_pkg::DIM_W'(1);
      end
    end
  end

endmodule

@@ src/ubl_queue.sv @@
// ---------------------------------------------------------------------------
// ubl_queue : short tag queue between front and back
// Small register FIFO; head is shown combinationally.
// ---------------------------------------------------------------------------
module ubl_queue #(
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ubl_pkg::tag_t       push_tag,
  input  logic [ADDR_W-1:0]   push_addr,
  output logic                q_full,
  output logic                q_valid,
  input  logic                pop,
  output ubl_pkg::tag_t       head_tag,
  output logic [ADDR_W-1:0]   head_addr
);

  localparam int CW = ubl_pkg::Q_PTR_W + 1;

  ubl_pkg::tag_t                tag_r  [ubl_pkg::Q_DEPTH];
  logic [ADDR_W-1:0]            addr_r [ubl_pkg::Q_DEPTH];
  logic [ubl_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [ubl_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [CW-1:0]                cnt_r;

  assign q_full    = (cnt_r == CW'(ubl_pkg::Q_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign head_tag  = tag_r[rd_ptr_r];
  assign head_addr = addr_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      tag_r[wr_ptr_r]  <= push_tag;
      addr_r[wr_ptr_r] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ubl_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ubl_pkg::Q_PTR_W'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

@@ src/ubl_back.sv @@
// ---------------------------------------------------------------------------
// ubl_back : run tracking, square detection and result output
// Column run memory with read-modify-write, horizontal runs, frame report.
// ---------------------------------------------------------------------------
module ubl_back #(
  parameter int MAX_WIDTH = ubl_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ubl_pkg::tag_t     head_tag,
  input  logic [ADDR_W-1:0] head_addr,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output ubl_pkg::result_t  out_result
);

  typedef logic [ubl_pkg::ENTRY_W-1:0] entry_t;
  typedef logic [ubl_pkg::RUN_W-1:0]   run_t;

  function automatic logic [ubl_pkg::POS_W:0] abs_diff(ubl_pkg::pos_t a, ubl_pkg::pos_t b);
    logic signed [ubl_pkg::POS_W:0] d;
    d = {a[ubl_pkg::POS_W-1], a} - {b[ubl_pkg::POS_W-1], b};
    return d[ubl_pkg::POS_W] ? -d : d;
  endfunction

  function automatic run_t sat_inc(run_t x);
    return (x < ubl_pkg::RUN_LEN) ? x + run_t'(1) : ubl_pkg::RUN_LEN;
  endfunction

  // run memory, clearing pass
  entry_t            mem [MAX_WIDTH];
  entry_t            rd_data_r;
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  // stage two
  logic              s2_valid_r;
  ubl_pkg::tag_t     s2_tag_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic              fwd_hit_r;
  entry_t            fwd_data_r;

  // frame state
  run_t              zh_r, oh_r;
  ubl_pkg::pos_t     found_r [4];
  ubl_pkg::status_t  err_r;

  // stage two combinational results
  entry_t            entry;
  run_t              plen;
  run_t              len;
  logic              vbit;
  logic              is_bin;
  entry_t            wr_data;
  run_t              zh_nxt, oh_nxt;
  run_t              zh_base, oh_base;
  ubl_pkg::pos_t     found_nxt [4];
  ubl_pkg::status_t  err_nxt;
  ubl_pkg::status_t  status;
  logic [ubl_pkg::POS_W:0] dcol, drow;

  // output buffer, two entries
  ubl_pkg::result_t  ob_r [2];
  logic              ob_wr_r, ob_rd_r;
  logic [1:0]        ob_cnt_r;
  logic              res_push;
  logic              deq;
  logic              room;

  always_comb begin
    entry  = fwd_hit_r ? fwd_data_r : rd_data_r;
    plen   = s2_tag_r.row_first ? run_t'(0) : entry[ubl_pkg::RUN_W-1:0];
    is_bin = (s2_tag_r.cls != ubl_pkg::CLS_OTHER);
    vbit   = (s2_tag_r.cls == ubl_pkg::CLS_ONE);
    len    = '0;
    if (is_bin) begin
      len = (plen != '0 && entry[ubl_pkg::RUN_W] == vbit) ? sat_inc(plen) : run_t'(1);
    end
    wr_data = is_bin ? {vbit, len} : '0;

    zh_base = s2_tag_r.col_first ? run_t'(0) : zh_r;
    oh_base = s2_tag_r.col_first ? run_t'(0) : oh_r;
    zh_nxt  = (s2_tag_r.cls == ubl_pkg::CLS_ZERO && len == ubl_pkg::RUN_LEN) ?
              sat_inc(zh_base) : run_t'(0);
    oh_nxt  = (s2_tag_r.cls == ubl_pkg::CLS_ONE && len == ubl_pkg::RUN_LEN) ?
              sat_inc(oh_base) : run_t'(0);

    found_nxt = found_r;
    err_nxt   = err_r;
    // first error in scan order wins; positions before it are kept
    if (zh_nxt == ubl_pkg::RUN_LEN && err_nxt == ubl_pkg::ST_OK) begin
      if (found_nxt[0] != ubl_pkg::POS_NONE && found_nxt[1] != ubl_pkg::POS_NONE) begin
        err_nxt = ubl_pkg::ST_DUP_ZERO;
      end else begin
        found_nxt[0] = s2_tag_r.pos_col;
        found_nxt[1] = s2_tag_r.pos_row;
      end
    end
    if (oh_nxt == ubl_pkg::RUN_LEN && err_nxt == ubl_pkg::ST_OK) begin
      if (found_nxt[2] != ubl_pkg::POS_NONE && found_nxt[3] != ubl_pkg::POS_NONE) begin
        err_nxt = ubl_pkg::ST_DUP_ONE;
      end else begin
        found_nxt[2] = s2_tag_r.pos_col;
        found_nxt[3] = s2_tag_r.pos_row;
      end
    end

    // side-by-side test on the stored values, -1 included
    dcol   = abs_diff(found_nxt[0], found_nxt[2]);
    drow   = abs_diff(found_nxt[1], found_nxt[3]);
    status = err_nxt;
    if (err_nxt == ubl_pkg::ST_OK &&
        ((dcol < 12'd5 && drow == 12'd5) || (drow < 12'd5 && dcol == 12'd5))) begin
      status = ubl_pkg::ST_ADJACENT;
    end
  end

  // issue control: a popped item always finds room for its result
  assign res_push  = s2_valid_r & s2_tag_r.frame_end;
  assign out_valid = (ob_cnt_r != 2'd0);
  assign deq       = out_valid & ~out_stall;
  assign room      = ({1'b0, ob_cnt_r} + 3'(res_push) - 3'(deq)) < 3'd2;
  assign pop       = q_valid & ~clr_active_r & room;
  assign clearing  = clr_active_r;
  assign out_result = ob_r[ob_rd_r];

  always_comb begin
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s2_valid_r;
      mem_waddr = s2_addr_r;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data_r <= mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_tag_r   <= head_tag;
      s2_addr_r  <= head_addr;
      fwd_data_r <= wr_data;
    end
    if (res_push) begin
      ob_r[ob_wr_r] <= '{status:      status,
                         zero_column: found_nxt[0],
                         zero_row:    found_nxt[1],
                         one_column:  found_nxt[2],
                         one_row:     found_nxt[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s2_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      zh_r         <= '0;
      oh_r         <= '0;
      found_r      <= '{default: ubl_pkg::POS_NONE};
      err_r        <= ubl_pkg::ST_OK;
      ob_wr_r      <= 1'b0;
      ob_rd_r      <= 1'b0;
      ob_cnt_r     <= 2'd0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(MAX_WIDTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      s2_valid_r <= pop;
      // back-to-back on one column: the memory read missed this write
      fwd_hit_r  <= pop & s2_valid_r & (s2_addr_r == head_addr);
      if (s2_valid_r) begin
        zh_r <= zh_nxt;
        oh_r <= oh_nxt;
        if (s2_tag_r.frame_end) begin
          found_r <= '{default: ubl_pkg::POS_NONE};
          err_r   <= ubl_pkg::ST_OK;
          zh_r    <= '0;
          oh_r    <= '0;
        end else begin
          found_r <= found_nxt;
          err_r   <= err_nxt;
        end
      end
      if (res_push) begin
        ob_wr_r <= ~ob_wr_r;
      end
      if (deq) begin
        ob_rd_r <= ~ob_rd_r;
      end
      ob_cnt_r <= ob_cnt_r + 2'(res_push) - 2'(deq);
    end
  end

endmodule

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb : self-checking bench for the uniform block locator
// Streams pixel frames with planted 5x5 squares, predicts each frame's result
// item in a local model of the scan and compares it field by field.
// ---------------------------------------------------------------------------
module tb;

  localparam int LATENCY_PAUSE = 8;    // margin for a result still in the result path
  localparam int LONG_HOLD     = 300;  // receiver hold-off for the fill-up test
  localparam int IMG_MAX       = 40;   // largest frame side built in the image buffer
  localparam int REPORT_CAP    = 100;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ubl_pkg::PADDR_W-1:0] paddr = '0;
  logic [ubl_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ubl_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [7:0]                  in_pixel_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  out_status;
  ubl_pkg::pos_t               out_zero_column;
  ubl_pkg::pos_t               out_zero_row;
  ubl_pkg::pos_t               out_one_column;
  ubl_pkg::pos_t               out_one_row;

  always #2 clk = ~clk;

  uniform_block_locator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_zero_column (out_zero_column),
    .out_zero_row    (out_zero_row),
    .out_one_column  (out_one_column),
    .out_one_row     (out_one_row)
  );

  // -------------------------------------------------------------------------
  // Scan model: per-column vertical runs, horizontal runs, frame position
  // -------------------------------------------------------------------------
  logic [ubl_pkg::DIM_W-1:0] frame_w;
  logic [ubl_pkg::DIM_W-1:0] frame_h;
  logic [3:0]                col_runs [0:ubl_pkg::MAX_WIDTH_DEF-1];  // {value, length}
  int unsigned               zero_hrun;
  int unsigned               one_hrun;
  int unsigned               col_cnt;
  int unsigned               row_cnt;
  int                        found_pos [4];        // zero col/row, one col/row
  ubl_pkg::status_t          dup_code;

  ubl_pkg::result_t          frame_results [$];    // result items still owed
  int                        mismatches = 0;
  int unsigned               pixels_sent = 0;
  string                     pos_name [4] = '{"zero_column", "zero_row",
                                              "one_column", "one_row"};

  // stimulus shaping, written by the test sequence only
  int                        idle_pct = 0;
  int                        stall_pct = 0;
  logic                      hold_req = 1'b0;

  logic [7:0]                img [0:IMG_MAX-1][0:IMG_MAX-1];

  function automatic void clear_frame_state();
    zero_hrun = 0;
    one_hrun  = 0;
    col_cnt   = 0;
    row_cnt   = 0;
    found_pos = '{-1, -1, -1, -1};
    dup_code  = ubl_pkg::ST_OK;
  endfunction

  function automatic void reset_scan_model();
    int k;
    frame_w = ubl_pkg::FRAME_DIM_RESET;
    frame_h = ubl_pkg::FRAME_DIM_RESET;
    for (k = 0; k < ubl_pkg::MAX_WIDTH_DEF; k++) col_runs[k] = '0;
    clear_frame_state();
  endfunction

  // a second square of the same value latches the first duplicate error
  function automatic void note_square(input int slot, input ubl_pkg::status_t code,
                                      input int col, input int row);
    if (dup_code != ubl_pkg::ST_OK) return;
    if (found_pos[slot] != -1 && found_pos[slot+1] != -1) begin
      dup_code = code;
    end else begin
      found_pos[slot]   = col;
      found_pos[slot+1] = row;
    end
  endfunction

  // advance the scan by one accepted pixel; queue the frame result at frame end
  task automatic scan_pixel(input logic [7:0] v);
    int unsigned      w, h, c, r, plen, len;
    logic             pval;
    int               zc, zr, oc, orow, dc, dr;
    ubl_pkg::status_t frame_status;
    ubl_pkg::result_t res;
    w = (frame_w == 0) ? 1 : frame_w;
    if (w > ubl_pkg::MAX_WIDTH_DEF) w = ubl_pkg::MAX_WIDTH_DEF;
    h = (frame_h == 0) ? 1 : frame_h;
    c = col_cnt % ubl_pkg::MAX_WIDTH_DEF;
    r = row_cnt;
    plen = (r == 0) ? 0 : col_runs[c][2:0];
    pval = col_runs[c][3];
    len  = 0;
    // anything other than 0 or 1 breaks both runs
    if (v <= 8'd1) begin
      len = (plen > 0 && pval == v[0]) ? plen + 1 : 1;
      if (len > 5) len = 5;
      col_runs[c] = {v[0], len[2:0]};
    end else begin
      col_runs[c] = '0;
    end
    if (c == 0) begin
      zero_hrun = 0;
      one_hrun  = 0;
    end
    zero_hrun = (v == 8'd0 && len == 5) ? ((zero_hrun < 5) ? zero_hrun + 1 : 5) : 0;
    one_hrun  = (v == 8'd1 && len == 5) ? ((one_hrun < 5) ? one_hrun + 1 : 5) : 0;
    if (zero_hrun == 5)
      note_square(0, ubl_pkg::ST_DUP_ZERO, int'(c) - 2, int'(h) - int'(r) + 1);
    if (one_hrun == 5)
      note_square(2, ubl_pkg::ST_DUP_ONE, int'(c) - 2, int'(h) - int'(r) + 1);

    if (col_cnt + 1 < w) begin
      col_cnt++;
      return;
    end
    col_cnt = 0;
    if (row_cnt + 1 < h) begin
      row_cnt++;
      return;
    end

    frame_status = dup_code;
    zc   = found_pos[0];
    zr   = found_pos[1];
    oc   = found_pos[2];
    orow = found_pos[3];
    // side-by-side only when no duplicate; absent squares count as -1
    if (frame_status == ubl_pkg::ST_OK) begin
      dc = (zc > oc) ? zc - oc : oc - zc;
      dr = (zr > orow) ? zr - orow : orow - zr;
      if ((dc < 5 && dr == 5) || (dr < 5 && dc == 5)) frame_status = ubl_pkg::ST_ADJACENT;
    end
    res.status      = frame_status;
    res.zero_column = zc[ubl_pkg::POS_W-1:0];
    res.zero_row    = zr[ubl_pkg::POS_W-1:0];
    res.one_column  = oc[ubl_pkg::POS_W-1:0];
    res.one_row     = orow[ubl_pkg::POS_W-1:0];
    frame_results = {frame_results, res};
    clear_frame_state();
  endtask

  // -------------------------------------------------------------------------
  // Result side: random or long stall, and the checker
  // -------------------------------------------------------------------------
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    ubl_pkg::result_t want;
    ubl_pkg::pos_t    got_pos [4];
    ubl_pkg::pos_t    want_pos [4];
    int               k;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results.size() == 0) begin
        report_mismatch("result item with no frame outstanding");
      end else begin
        want = frame_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        got_pos  = '{out_zero_column, out_zero_row, out_one_column, out_one_row};
        want_pos = '{want.zero_column, want.zero_row, want.one_column, want.one_row};
        for (k = 0; k < 4; k++)
          if (got_pos[k] !== want_pos[k])
            report_mismatch($sformatf("%s got %0d want %0d",
                                      pos_name[k], got_pos[k], want_pos[k]));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Pixel side and configuration
  // -------------------------------------------------------------------------
  task automatic send_pixel(input logic [7:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= v;
    do @(posedge clk); while (in_stall);
    scan_pixel(v);
    pixels_sent++;
  endtask

  // nothing owed, then enough cycles for a pixel still in the pipe
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (LATENCY_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ubl_pkg::DIM_W-1:0] value);
    logic [ubl_pkg::PDATA_W-1:0] data;
    logic [ubl_pkg::PADDR_W-1:0] addr;
    data = $urandom;                   // upper bits are don't-care
    data[ubl_pkg::DIM_W-1:0] = value;
    addr = '0;
    addr[ubl_pkg::REG_SEL_BIT] = idx;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == ubl_pkg::REG_IDX_WIDTH) frame_w = value;
    else frame_h = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_idle();
    write_reg(ubl_pkg::REG_IDX_WIDTH, w[ubl_pkg::DIM_W-1:0]);
    write_reg(ubl_pkg::REG_IDX_HEIGHT, h[ubl_pkg::DIM_W-1:0]);
  endtask

  task automatic fill_image(input logic [7:0] v);
    int i, j;
    for (i = 0; i < IMG_MAX; i++)
      for (j = 0; j < IMG_MAX; j++) img[i][j] = v;
  endtask

  task automatic plant_square(input logic [7:0] v, input int top, input int left);
    int i, j;
    for (i = 0; i < 5; i++)
      for (j = 0; j < 5; j++) img[top+i][left+j] = v;
  endtask

  // whole frame from the image buffer at the current geometry
  task automatic send_frame();
    int unsigned w, h, r, c;
    w = (frame_w == 0) ? 1 : frame_w;
    h = (frame_h == 0) ? 1 : frame_h;
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++) send_pixel(img[r][c]);
  endtask

  task automatic build_random_image(input int w, input int h);
    int i, j, k, mode, zi, zj, oi, oj;
    logic [7:0] solid;
    mode  = $urandom_range(0, 3);
    solid = 8'($urandom_range(0, 1));
    for (i = 0; i < h; i++)
      for (j = 0; j < w; j++) begin
        k = $urandom_range(0, 29);
        unique case (mode)
          0: img[i][j] = 8'($urandom_range(0, 255));
          1: img[i][j] = (k < 14) ? 8'd0 : (k < 28) ? 8'd1 : 8'($urandom_range(2, 255));
          2: img[i][j] = (k == 0) ? 8'($urandom_range(2, 255)) : solid;
          default: img[i][j] = 8'($urandom_range(2, 255));
        endcase
      end
    if (w < 5 || h < 5) return;
    repeat ($urandom_range(0, 2)) plant_square(8'd0, $urandom_range(0, h-5), $urandom_range(0, w-5));
    repeat ($urandom_range(0, 2)) plant_square(8'd1, $urandom_range(0, h-5), $urandom_range(0, w-5));
    // pair that may sit side by side: five apart on one axis, skewed on the other
    if ($urandom_range(0, 2) == 0) begin
      zi = $urandom_range(0, h-5);
      zj = $urandom_range(0, w-5);
      if ($urandom_range(0, 1)) begin
        oi = zi + ($urandom_range(0, 1) ? 5 : -5);
        oj = zj + int'($urandom_range(0, 8)) - 4;
      end else begin
        oj = zj + ($urandom_range(0, 1) ? 5 : -5);
        oi = zi + int'($urandom_range(0, 8)) - 4;
      end
      plant_square(8'd0, zi, zj);
      if (oi >= 0 && oj >= 0 && oi <= h-5 && oj <= w-5) plant_square(8'd1, oi, oj);
    end
    // now and then a broken square
    if ($urandom_range(0, 4) == 0)
      img[$urandom_range(0, h-1)][$urandom_range(0, w-1)] = 8'($urandom_range(0, 255));
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // reset geometry 10 x 10, one square of each value, corner to corner
  task automatic test_reset_frame();
    fill_image(8'hA5);
    plant_square(8'd0, 0, 0);
    plant_square(8'd1, 5, 5);
    send_frame();
  endtask

  // frame too small for a square; walks pixel values across all bits
  task automatic test_pixel_extremes();
    logic [7:0] vals [16];
    int k;
    vals = '{8'h00, 8'h01, 8'h02, 8'hFF, 8'h80, 8'h7F, 8'hFE, 8'h55,
             8'hAA, 8'h01, 8'h00, 8'h03, 8'h40, 8'h20, 8'h10, 8'h08};
    set_frame(4, 4);
    for (k = 0; k < 16; k++) send_pixel(vals[k]);
  endtask

  // squares touching on one side
  task automatic test_side_by_side();
    set_frame(10, 5);
    fill_image(8'h33);
    plant_square(8'd0, 0, 0);
    plant_square(8'd1, 0, 5);
    send_frame();
    set_frame(6, 10);
    fill_image(8'h33);
    plant_square(8'd1, 0, 1);
    plant_square(8'd0, 5, 0);
    send_frame();
  endtask

  // second square of one value; the first error holds
  task automatic test_duplicates();
    set_frame(15, 5);
    fill_image(8'hC3);
    plant_square(8'd0, 0, 0);
    plant_square(8'd1, 0, 5);
    plant_square(8'd0, 0, 10);
    send_frame();
    set_frame(20, 5);
    fill_image(8'hC3);
    plant_square(8'd1, 0, 0);
    plant_square(8'd1, 0, 5);
    plant_square(8'd0, 0, 10);
    plant_square(8'd0, 0, 15);
    send_frame();
    // solid frames overlap many windows
    set_frame(6, 6);
    fill_image(8'd0);
    send_frame();
    fill_image(8'd1);
    send_frame();
  endtask

  // runs that wrap from the right edge into the next row must not match
  task automatic test_right_edge();
    int i, j;
    set_frame(7, 6);
    fill_image(8'h09);
    for (i = 0; i < 6; i++)
      for (j = 0; j < 7; j++)
        if (j >= 4 || j <= 1) img[i][j] = 8'd0;
    send_frame();
  endtask

  // a zero-size register acts as 1: 0 x 0 gives a 1 x 1 frame, 0 x 7 a 1 x 7 one
  task automatic test_zero_dimensions();
    set_frame(0, 0);
    repeat (3) send_pixel(8'($urandom_range(0, 255)));
    set_frame(0, 7);
    repeat (7) send_pixel(8'd0);
  endtask

  // widest register value over one row; tallest one with a square at the top,
  // then the height shrinks so the frame ends after the next row
  task automatic test_extreme_geometry();
    int r, c;
    set_frame(1023, 1);
    for (c = 0; c < 1023; c++) send_pixel(8'($urandom_range(0, 1)));
    set_frame(5, 1023);
    for (r = 0; r < 5; r++)
      for (c = 0; c < 5; c++) send_pixel(8'd1);
    wait_idle();
    write_reg(ubl_pkg::REG_IDX_HEIGHT, 10'd1);
    for (c = 0; c < 5; c++) send_pixel(8'($urandom_range(0, 255)));
  endtask

  // shrink both registers part way through a frame: ends on the next pixel,
  // and the square found there reports a row below zero
  task automatic test_resize_mid_frame();
    int r, c;
    set_frame(12, 12);
    fill_image(8'h33);
    plant_square(8'd0, 2, 0);
    for (r = 0; r < 6; r++)
      for (c = 0; c < 12; c++) send_pixel(img[r][c]);
    for (c = 0; c < 4; c++) send_pixel(img[6][c]);
    wait_idle();
    write_reg(ubl_pkg::REG_IDX_WIDTH, 10'd3);
    write_reg(ubl_pkg::REG_IDX_HEIGHT, 10'd3);
    send_pixel(img[6][4]);
  endtask

  // random frames over four idling phases
  task automatic test_random_frames();
    int          idle_by_phase [4] = '{0, 83, 0, 29};
    int          stall_by_phase [4] = '{0, 0, 83, 29};
    int          p, frames;
    int unsigned w, h, start;
    for (p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      start     = pixels_sent;
      frames    = 0;
      while (pixels_sent - start < 20 || frames < 2) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, IMG_MAX) : $urandom_range(1, 12);
        h = $urandom_range(1, 10);
        if ($urandom_range(0, 24) == 0) w = 0;
        if ($urandom_range(0, 24) == 0) h = 0;
        set_frame(w, h);
        // one or two frames back to back at one geometry
        repeat ($urandom_range(1, 2)) begin
          build_random_image((w == 0) ? 1 : w, (h == 0) ? 1 : h);
          send_frame();
          frames++;
        end
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // 1 x 1 frames give a result per pixel; a long hold fills the block up
  task automatic test_result_backpressure();
    set_frame(1, 1);
    hold_req = ~hold_req;
    repeat (60) send_pixel(8'($urandom_range(0, 1)));
  endtask

  initial begin
    reset_scan_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_frame();
    test_pixel_extremes();
    test_side_by_side();
    test_duplicates();
    test_right_edge();
    test_zero_dimensions();
    test_resize_mid_frame();
    test_extreme_geometry();
    test_random_frames();
    test_result_backpressure();
    wait_idle();

    if (mismatches == 0 && frame_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
